// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the averager RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define BVA_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked check that also holds through reset.
`define BVA_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ----- rtl/bva_pkg.sv -----
// Shared types and fixed widths of the battery voltage averager.
// Depends on nothing; imported by every averager module.
package bva_pkg;

   localparam int SAMPLE_W   = 12;
   localparam int SCALE_W    = 24;
   localparam int THRESH_W   = 16;
   localparam int MV_W       = 16;
   localparam int Q_FRAC     = 16;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [SCALE_W-1:0]  SCALE_RESET  = 24'd105625;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd0;

   // Register select is the word index taken from paddr bit 2.
   localparam logic REG_SCALE  = 1'b0;
   localparam logic REG_THRESH = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- rtl/bva_ring.sv -----
// Sample ring memory with running window sum, write slot and fill flag.
// Depends on bva_pkg.
module bva_ring #(
   parameter int WINDOW_LEN = 16,
   parameter int SUM_W      = 16,
   parameter int CNT_W      = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bva_pkg::SAMPLE_W-1:0]  sample,
   output logic                          done,
   output logic [SUM_W-1:0]              sum,
   output logic [CNT_W-1:0]              count,
   output logic                          filled,
   output logic [bva_pkg::SAMPLE_W-1:0]  latest
);
   import bva_pkg::*;

   localparam int SLOT_W = $clog2(WINDOW_LEN);

   logic [SAMPLE_W-1:0] mem [WINDOW_LEN];
   logic [SAMPLE_W-1:0] rd_ff;
   logic [SAMPLE_W-1:0] samp_ff;
   logic                pend_ff;
   logic                done_ff;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                filled_ff, filled_in;
   logic [SAMPLE_W-1:0] old_val;

   // Slots at or past the write slot have not been written before the first
   // wrap, so their contents are ignored and zero stands in for the old value.
   assign old_val = filled_ff ? rd_ff : '0;

   always_comb begin
      sum_in    = sum_ff - SUM_W'(old_val) + SUM_W'(samp_ff);
      slot_in   = slot_ff + 1'b1;
      filled_in = filled_ff;
      if (slot_ff == SLOT_W'(WINDOW_LEN - 1)) begin
         slot_in   = '0;
         filled_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rd_ff   <= mem[slot_ff];
         samp_ff <= sample;
      end
      if (pend_ff) begin
         mem[slot_ff] <= samp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= 1'b0;
         done_ff   <= 1'b0;
         sum_ff    <= '0;
         slot_ff   <= '0;
         filled_ff <= 1'b0;
      end else begin
         pend_ff <= start;
         done_ff <= pend_ff;
         if (pend_ff) begin
            sum_ff    <= sum_in;
            slot_ff   <= slot_in;
            filled_ff <= filled_in;
         end
      end
   end

   assign done   = done_ff;
   assign sum    = sum_ff;
   assign count  = filled_ff ? CNT_W'(WINDOW_LEN) : CNT_W'(slot_ff);
   assign filled = filled_ff;
   assign latest = samp_ff;

endmodule

// ----- rtl/bva_divider.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on bva_pkg for its status struct.
module bva_divider #(
   parameter int DIV_W  = 24,
   parameter int DEN_W  = 5,
   parameter int STEP_W = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [DIV_W-1:0]       dividend,
   input  logic [DEN_W-1:0]       divisor,
   input  logic [STEP_W-1:0]      steps,
   output bva_pkg::div_status_type status,
   output logic [DIV_W-1:0]       quotient
);
   import bva_pkg::*;

   logic [DIV_W-1:0]  dvd_ff;
   logic [DIV_W-1:0]  q_ff;
   logic [DEN_W-1:0]  d_ff;
   logic [DEN_W-1:0]  r_ff, r_in;
   logic [STEP_W-1:0] cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DEN_W:0]    r_sh;
   logic [DEN_W:0]    diff;
   logic              ge;

   always_comb begin
      r_sh = {r_ff, dvd_ff[DIV_W-1]};
      diff = r_sh - {1'b0, d_ff};
      ge   = (r_sh >= {1'b0, d_ff});
      r_in = ge ? diff[DEN_W-1:0] : r_sh[DEN_W-1:0];
   end

   // The dividend is consumed from its top bit, so a short run divides only
   // the upper bits of a left-aligned operand.
   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         dvd_ff <= dividend;
         d_ff   <= divisor;
         q_ff   <= '0;
         r_ff   <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DIV_W-2:0], 1'b0};
         q_ff   <= {q_ff[DIV_W-2:0], ge};
         r_ff   <= r_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = q_ff;

endmodule

// ----- rtl/battery_voltage_averager_core.sv -----
// Battery voltage averager top level: request/result streams, APB registers,
// sequencer and multiplier. Depends on bva_pkg, bva_ring, bva_divider and
// assert_macros.svh.
//
// Usage:
// A request carries one 12-bit converter sample in req_tdata[11:0]. It is
// stored in a ring of WINDOW_LEN slots and the window sum is updated. One
// result follows each request: latest sample, floored average, battery
// voltage in millivolts (saturated at 65535), a low-battery flag and a
// window-full flag.
// The shared bit-serial divider runs once for the average and once for the
// voltage, where SUM_W = 12 + log2(WINDOW_LEN) and DIV_W = SUM_W + 8. One
// request is in work at a time: the next request is accepted only once the
// result of the previous one has been loaded into the output register.
// The result sits in an output register until taken; the next request is
// accepted meanwhile, and its result waits if the previous one is stalled.
// Reset clears the ring contents (by fill tracking), the sum, the write slot
// and the fill flag, and loads voltage_scale = 105625, low_threshold_mv = 0.
// Registers: voltage_scale at byte address 0, low_threshold_mv at 4.
`include "assert_macros.svh"

module battery_voltage_averager_core #(
   parameter int WINDOW_LEN = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [11:0] sample
   input  logic [bva_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [11:0] latest_sample, [23:12] average_raw, [39:24] voltage_mv,
   // [40] low_battery, [41] window_full
   output logic [bva_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bva_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [bva_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [bva_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import bva_pkg::*;

   localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LEN);
   localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
   localparam int PROD_W = SUM_W + SCALE_W;
   localparam int DIV_W  = PROD_W - Q_FRAC;
   localparam int STEP_W = $clog2(DIV_W + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RING = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_AVG  = 3'd3;
   localparam logic [2:0] S_MV   = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [SCALE_W-1:0]  scale_ff;
   logic [THRESH_W-1:0] thresh_ff;
   logic                csr_wr;

   logic                req_fire;
   logic                ring_done;
   logic [SUM_W-1:0]    ring_sum;
   logic [CNT_W-1:0]    ring_count;
   logic                ring_filled;
   logic [SAMPLE_W-1:0] ring_latest;

   logic [PROD_W-1:0]   product_ff;
   logic                div_start;
   logic [DIV_W-1:0]    div_dividend;
   logic [STEP_W-1:0]   div_steps;
   div_status_type      div_stat;
   logic [DIV_W-1:0]    div_quot;

   logic [SAMPLE_W-1:0] avg_ff;
   logic [MV_W-1:0]     mv_ff, mv_in;
   logic                rsp_load;
   logic                rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= SCALE_RESET;
         thresh_ff <= THRESH_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_SCALE:  scale_ff  <= csr_pwdata[SCALE_W-1:0];
            REG_THRESH: thresh_ff <= csr_pwdata[THRESH_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_SCALE:  csr_prdata = CSR_DATA_W'(scale_ff);
         REG_THRESH: csr_prdata = CSR_DATA_W'(thresh_ff);
         default:    csr_prdata = '0;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   bva_ring #(
      .WINDOW_LEN (WINDOW_LEN),
      .SUM_W      (SUM_W),
      .CNT_W      (CNT_W)
   ) u_ring (
      .clock  (clock),
      .reset  (reset),
      .start  (req_fire),
      .sample (req_tdata[SAMPLE_W-1:0]),
      .done   (ring_done),
      .sum    (ring_sum),
      .count  (ring_count),
      .filled (ring_filled),
      .latest (ring_latest)
   );

   bva_divider #(
      .DIV_W  (DIV_W),
      .DEN_W  (CNT_W),
      .STEP_W (STEP_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (ring_count),
      .steps    (div_steps),
      .status   (div_stat),
      .quotient (div_quot)
   );

   // The first pass divides the sum, left-aligned, over SUM_W steps. The second
   // divides product / 65536, which equals the full quotient after flooring.
   always_comb begin
      div_start    = 1'b0;
      div_dividend = {ring_sum, {(DIV_W - SUM_W){1'b0}}};
      div_steps    = STEP_W'(SUM_W);
      if (state_ff == S_MUL) begin
         div_start = 1'b1;
      end else if (state_ff == S_AVG && div_stat.done) begin
         div_start    = 1'b1;
         div_dividend = product_ff[PROD_W-1:Q_FRAC];
         div_steps    = STEP_W'(DIV_W);
      end
   end

   assign mv_in    = (|div_quot[DIV_W-1:MV_W]) ? {MV_W{1'b1}} : div_quot[MV_W-1:0];
   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_fire) state_in = S_RING;
         S_RING:  if (ring_done) state_in = S_MUL;
         S_MUL:   state_in = S_AVG;
         S_AVG:   if (div_stat.done) state_in = S_MV;
         S_MV:    if (div_stat.done) state_in = S_OUT;
         S_OUT:   if (rsp_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_MUL) begin
         product_ff <= ring_sum * scale_ff;
      end
      if (state_ff == S_AVG && div_stat.done) begin
         avg_ff <= div_quot[SAMPLE_W-1:0];
      end
      if (state_ff == S_MV && div_stat.done) begin
         mv_ff <= mv_in;
      end
      if (rsp_load) begin
         rsp_data_ff <= RSP_DATA_W'({ring_filled, (mv_ff < thresh_ff), mv_ff,
                                     avg_ff, ring_latest});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `BVA_ASSERT(a_reset_idle, clock, reset |=> (state_ff == S_IDLE && !rsp_valid_ff), "reset did not return to idle")
   `BVA_ASSERT_RST(a_div_free, clock, reset, div_start |-> !div_stat.busy, "divider started while busy")
   `BVA_ASSERT_RST(a_count_nz, clock, reset, div_start |-> (ring_count != '0), "division by a zero count")
   `BVA_ASSERT_RST(a_avg_fits, clock, reset, (state_ff == S_AVG && div_stat.done) |-> (div_quot[DIV_W-1:SAMPLE_W] == '0), "average exceeds sample range")
   `BVA_ASSERT_RST(a_no_overwrite, clock, reset, (rsp_valid_ff && !rsp_tready) |=> $stable(rsp_data_ff), "pending result overwritten")

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for battery_voltage_averager_core: streams samples, predicts each result
// from a local window model and checks it field by field. Depends on bva_pkg and the RTL.
module tb_top;
   import bva_pkg::*;

   localparam int WINDOW     = 16;
   localparam int CYCLE_CAP  = 400000;
   localparam int DRAIN_WAIT = 60;

   typedef struct {
      logic [SAMPLE_W-1:0] latest;
      logic [SAMPLE_W-1:0] average;
      logic [MV_W-1:0]     millivolts;
      logic                low_flag;
      logic                full_flag;
   } reading_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Local copy of the filter state and the registers.
   logic [SAMPLE_W-1:0]   win_ring [WINDOW];
   logic [15:0]           win_sum;
   int unsigned           win_slot;
   logic                  win_filled;
   logic [SCALE_W-1:0]    cfg_scale;
   logic [THRESH_W-1:0]   cfg_thresh;

   reading_type           pending_readings[$];
   int                    error_count = 0;
   int                    cycle_count = 0;
   int                    stall_left = 0;
   bit                    idling = 1'b1;

   battery_voltage_averager_core #(.WINDOW_LEN(WINDOW)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic reading_type advance_window(input logic [SAMPLE_W-1:0] s);
      reading_type r;
      int unsigned count;
      logic [63:0] mv;
      win_sum = win_sum - win_ring[win_slot] + s;
      win_ring[win_slot] = s;
      if (win_slot == WINDOW - 1) begin
         win_slot = 0;
         win_filled = 1'b1;
      end else begin
         win_slot++;
      end
      count = win_filled ? WINDOW : win_slot;
      if (count == 0)
         count = 1;
      mv = (64'(win_sum) * 64'(cfg_scale)) / (64'(count) << Q_FRAC);
      if (mv > 64'd65535)
         mv = 64'd65535;
      r.latest     = s;
      r.average    = SAMPLE_W'(win_sum / count);
      r.millivolts = mv[MV_W-1:0];
      r.low_flag   = (mv < 64'(cfg_thresh));
      r.full_flag  = win_filled;
      return r;
   endfunction

   // Sends one sample; the request stays valid afterwards unless the next one idles first or the bench drains.
   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(s);
      do @(posedge clock); while (!req_tready);
      pending_readings.push_back(advance_window(s));
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_readings.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic reg_sel, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({reg_sel, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_sel == REG_SCALE)
         cfg_scale = value[SCALE_W-1:0];
      else
         cfg_thresh = value[THRESH_W-1:0];
      @(posedge clock);
   endtask

   task automatic read_check(input logic reg_sel);
      logic [CSR_DATA_W-1:0] want;
      want = (reg_sel == REG_SCALE) ? CSR_DATA_W'(cfg_scale) : CSR_DATA_W'(cfg_thresh);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'({reg_sel, 2'b00});
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want)
         report_mismatch($sformatf("register %0d read %h, expected %h",
                                   reg_sel, csr_prdata, want));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_and_verify(input logic reg_sel, input logic [CSR_DATA_W-1:0] value);
      write_reg(reg_sel, value);
      read_check(reg_sel);
   endtask

   task automatic test_register_reset();
      read_check(REG_SCALE);
      read_check(REG_THRESH);
   endtask

   // Covers the partial window, the wrap, saturation, a zero scale and the
   // masking of register bits above each register's width.
   task automatic test_directed_window();
      send_sample(12'hFFF);
      send_sample(12'h000);
      send_sample(12'h001);
      send_sample(12'h800);
      send_sample(12'h555);
      send_sample(12'hAAA);
      wait_for_drain();
      write_and_verify(REG_SCALE, 32'hFFFF_FFFF);
      write_and_verify(REG_THRESH, 32'hFFFF_FFFF);
      repeat (3) send_sample(12'hFFF);
      repeat (2) send_sample(12'h000);
      wait_for_drain();
      write_and_verify(REG_SCALE, 32'h0);
      write_and_verify(REG_THRESH, 32'h1);
      send_sample(12'd100);
      send_sample(12'hFFF);
      // Five more samples carry the write slot through its wrap.
      repeat (5) send_sample(12'(($urandom_range(0, 4095))));
      wait_for_drain();
      write_and_verify(REG_SCALE, 32'(SCALE_RESET));
      write_and_verify(REG_THRESH, 32'h0);
      repeat (3) send_sample(12'hFFF);
      wait_for_drain();
   endtask

   task automatic test_random_traffic();
      logic [CSR_DATA_W-1:0] value;
      int                    level;
      int                    s;
      for (int phase = 0; phase < 12; phase++) begin
         idling = (phase < 10);
         case ($urandom_range(0, 4))
            0:       value = 32'h0;
            1:       value = 32'h00FF_FFFF;
            2:       value = 32'(SCALE_RESET);
            3:       value = 32'($urandom_range(50000, 200000));
            default: value = $urandom;
         endcase
         write_and_verify(REG_SCALE, {8'($urandom_range(0, 255)), value[SCALE_W-1:0]});
         case ($urandom_range(0, 3))
            0:       value = 32'h0;
            1:       value = 32'hFFFF;
            2:       value = 32'($urandom_range(0, 8000));
            default: value = $urandom;
         endcase
         write_and_verify(REG_THRESH, value);
         level = $urandom_range(0, 4095);
         for (int n = 0; n < 50; n++) begin
            case ($urandom_range(0, 9))
               0, 1:    s = $urandom_range(0, 4095);
               2:       s = $urandom_range(0, 1) ? 4095 : 0;
               3:       s = $urandom_range(0, 1) ? $urandom_range(4031, 4095)
                                                 : $urandom_range(0, 64);
               default: s = level + $urandom_range(0, 64) - 32;
            endcase
            if (s < 0)
               s = 0;
            if (s > 4095)
               s = 4095;
            send_sample(12'(s));
         end
         wait_for_drain();
      end
   endtask

   // Result side: random stall bursts while idling is on.
   always @(posedge clock) begin
      if (stall_left > 0)
         stall_left = stall_left - 1;
      else if (idling && $urandom_range(0, 4) == 0)
         stall_left = $urandom_range(1, 5);
      rsp_tready <= (stall_left == 0);
   end

   always @(posedge clock) begin : check_results
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", rsp_tdata));
         end else begin
            want = pending_readings.pop_front();
            if (rsp_tdata[11:0] !== want.latest)
               report_mismatch($sformatf("latest_sample %h, expected %h",
                                         rsp_tdata[11:0], want.latest));
            if (rsp_tdata[23:12] !== want.average)
               report_mismatch($sformatf("average_raw %h, expected %h",
                                         rsp_tdata[23:12], want.average));
            if (rsp_tdata[39:24] !== want.millivolts)
               report_mismatch($sformatf("voltage_mv %0d, expected %0d",
                                         rsp_tdata[39:24], want.millivolts));
            if (rsp_tdata[40] !== want.low_flag)
               report_mismatch($sformatf("low_battery %b, expected %b",
                                         rsp_tdata[40], want.low_flag));
            if (rsp_tdata[41] !== want.full_flag)
               report_mismatch($sformatf("window_full %b, expected %b",
                                         rsp_tdata[41], want.full_flag));
            if (rsp_tdata[47:42] !== 6'b0)
               report_mismatch($sformatf("padding bits %b not zero", rsp_tdata[47:42]));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < WINDOW; i++)
         win_ring[i] = '0;
      win_sum    = '0;
      win_slot   = 0;
      win_filled = 1'b0;
      cfg_scale  = SCALE_RESET;
      cfg_thresh = THRESH_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_reset();
      test_directed_window();
      test_random_traffic();
      wait_for_drain();
      // Any stray result in this window shows up as unexpected.
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
